>>> design/set_assoc_cache_lru_tag_model_unit_macros.svh
// assertion helpers, sampled on clk_i and switched off while rst_ni is low
`ifndef SET_ASSOC_CACHE_LRU_TAG_MODEL_UNIT_MACROS_SVH
`define SET_ASSOC_CACHE_LRU_TAG_MODEL_UNIT_MACROS_SVH

// plain property
`define SACL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define SACL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> design/sacl_pkg.sv
`timescale 1ns / 1ps

package sacl_pkg;

  localparam int DEF_MAX_SET_BITS = 4;
  localparam int DEF_MAX_WAYS     = 4;

  localparam int ADDR_W     = 64;
  localparam int TAG_W      = 64;
  localparam int STAMP_W    = 32;
  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS    = 2'd0,
    CFG_WAYS_IN_USE = 2'd1,
    CFG_BLOCK_BITS  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0] set_bits;
    logic [2:0] ways_in_use;
    logic [5:0] block_bits;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } way_t;

endpackage

>>> design/sacl_ifs.sv
`timescale 1ns / 1ps

interface sacl_in_if;
  import sacl_pkg::*;
  logic              valid;
  logic              ready;
  logic              func;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output func, output address, input ready);
  modport sink (input valid, input func, input address, output ready);
endinterface

interface sacl_out_if;
  import sacl_pkg::*;
  logic             valid;
  logic             ready;
  logic             was_hit;
  logic             was_eviction;
  logic [CNT_W-1:0] hit_total;
  logic [CNT_W-1:0] miss_total;
  logic [CNT_W-1:0] eviction_total;
  logic             last;

  modport source (output valid, output was_hit, output was_eviction, output hit_total,
                  output miss_total, output eviction_total, output last, input ready);
  modport sink (input valid, input was_hit, input was_eviction, input hit_total,
                input miss_total, input eviction_total, input last, output ready);
endinterface

interface sacl_cfg_if;
  import sacl_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> design/set_assoc_cache_lru_tag_model_unit.sv
`timescale 1ns / 1ps
// Tag store of a set-associative cache with least-recently-used replacement.
// Each item (func, address) yields one result, or two when func marks a
// modify, the second flagged last and always a hit. An access reads the set
// row from the set memory, examines the ways one after another (up to
// ways_in_use, stopping early on a hit) and writes the row back, waiting
// while the last result is not taken; this serial way scan lies in the back
// end, which takes no new item before its last write-back. The front end
// splits set and tag, and a queue holds up to two further items. After reset
// a clearing pass empties all 2**MAX_SET_BITS sets of the set memory, during
// which no item is taken; configuration writes are taken at any time
// but must only be issued while the block is idle.

module set_assoc_cache_lru_tag_model_unit #(
  parameter int MAX_SET_BITS = sacl_pkg::DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = sacl_pkg::DEF_MAX_WAYS
) (
  input logic        clk_i,
  input logic        rst_ni,
  sacl_cfg_if.sink   cfg_i,
  sacl_in_if.sink    in_i,
  sacl_out_if.source res_o
);
  import sacl_pkg::*;

  localparam int SetW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int EntW = 1 + SetW + TAG_W;

  cfg_t            cfg_q;
  logic            clearing;
  logic            push_valid, push_ready, pop_valid, pop_ready;
  logic [EntW-1:0] push_data, pop_data;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.set_bits    <= 3'd0;
      cfg_q.ways_in_use <= 3'd1;
      cfg_q.block_bits  <= 6'd0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        CFG_SET_BITS:    cfg_q.set_bits    <= cfg_i.data[2:0];
        CFG_WAYS_IN_USE: cfg_q.ways_in_use <= cfg_i.data[2:0];
        CFG_BLOCK_BITS:  cfg_q.block_bits  <= cfg_i.data[5:0];
        default: ;
      endcase
    end
  end

  sacl_front #(
    .MAX_SET_BITS(MAX_SET_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .clearing_i   (clearing),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  sacl_queue #(
    .DATA_W(EntW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data),
    .pop_ready_i  (pop_ready)
  );

  sacl_back #(
    .MAX_SET_BITS(MAX_SET_BITS),
    .MAX_WAYS    (MAX_WAYS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .clearing_o  (clearing),
    .pop_valid_i (pop_valid),
    .pop_data_i  (pop_data),
    .pop_ready_o (pop_ready),
    .res_o       (res_o)
  );

endmodule

>>> design/sacl_front.sv
`timescale 1ns / 1ps

module sacl_front #(
  parameter int MAX_SET_BITS = sacl_pkg::DEF_MAX_SET_BITS,
  localparam int SetW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1,
  localparam int EntW = 1 + SetW + sacl_pkg::TAG_W
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sacl_pkg::cfg_t  cfg_i,
  input  logic            clearing_i,
  sacl_in_if.sink         in_i,
  output logic            push_valid_o,
  output logic [EntW-1:0] push_data_o,
  input  logic            push_ready_i
);
  import sacl_pkg::*;

  logic              valid_q, valid_d;
  logic [EntW-1:0]   ent_q;
  logic              accept;
  logic [2:0]        sb_eff;
  logic [ADDR_W-1:0] shifted;
  logic [TAG_W-1:0]  tag;
  logic [SetW-1:0]   set_idx;

  // split address into set and tag
  always_comb begin
    sb_eff  = (32'(cfg_i.set_bits) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : cfg_i.set_bits;
    shifted = in_i.address >> cfg_i.block_bits;
    tag     = shifted >> sb_eff;
    set_idx = shifted[SetW-1:0] & ~({SetW{1'b1}} << sb_eff);
  end

  assign in_i.ready   = (!valid_q || push_ready_i) && !clearing_i;
  assign accept       = in_i.valid && in_i.ready;
  assign push_valid_o = valid_q;
  assign push_data_o  = ent_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ent_q <= {in_i.func, set_idx, tag};
    end
  end

endmodule

>>> design/sacl_queue.sv
`timescale 1ns / 1ps

module sacl_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = sacl_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              push_ready_o,
  output logic              pop_valid_o,
  output logic [DATA_W-1:0] pop_data_o,
  input  logic              pop_ready_i
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] buf_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              push, pop;

  assign push_ready_o = cnt_q != CntW'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = buf_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> design/sacl_back.sv
`timescale 1ns / 1ps
`include "set_assoc_cache_lru_tag_model_unit_macros.svh"

module sacl_back #(
  parameter int MAX_SET_BITS = sacl_pkg::DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = sacl_pkg::DEF_MAX_WAYS,
  localparam int SetW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1,
  localparam int EntW = 1 + SetW + sacl_pkg::TAG_W
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sacl_pkg::cfg_t  cfg_i,
  output logic            clearing_o,
  input  logic            pop_valid_i,
  input  logic [EntW-1:0] pop_data_i,
  output logic            pop_ready_o,
  sacl_out_if.source      res_o
);
  import sacl_pkg::*;

  localparam int NumSets = 1 << MAX_SET_BITS;
  localparam int WayW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_WRITE = 2'd3;

  typedef way_t [MAX_WAYS-1:0] row_t;

  row_t mem_q [NumSets];
  row_t rd_row_q, new_row, mem_wdata;
  logic mem_we, mem_re, fwd;
  logic [SetW-1:0] mem_waddr, pop_set;

  logic [1:0]         state_q, state_d;
  logic [SetW-1:0]    clr_q, clr_d;
  logic [WayW-1:0]    way_q, way_d, last_way;
  logic               second_q, second_d;
  logic               modify_q;
  logic [SetW-1:0]    set_q;
  logic [TAG_W-1:0]   tag_q;
  logic               hit_q, hit_d, empty_q, empty_d, vic_q, vic_d;
  logic [WayW-1:0]    hit_way_q, hit_way_d, empty_way_q, empty_way_d, vic_way_q, vic_way_d;
  logic [STAMP_W-1:0] min_stamp_q, min_stamp_d;
  logic               scan_init;
  way_t               cur;
  logic [WayW-1:0]    tgt_way;
  logic               evict;
  logic               out_free, load;

  logic [STAMP_W-1:0] stamp_q;
  logic [CNT_W-1:0]   hit_cnt_q, miss_cnt_q, evict_cnt_q;
  logic [CNT_W-1:0]   hit_cnt_d, miss_cnt_d, evict_cnt_d;

  logic               out_valid_q, out_hit_q, out_evict_q, out_last_q;
  logic [CNT_W-1:0]   out_hit_tot_q, out_miss_tot_q, out_evict_tot_q;

  assign pop_set    = pop_data_i[EntW-2 -: SetW];
  assign clearing_o = state_q == S_CLEAR;
  assign out_free   = !out_valid_q || res_o.ready;

  always_comb begin
    if (cfg_i.ways_in_use == 3'd0) begin
      last_way = '0;
    end else if (32'(cfg_i.ways_in_use) > MAX_WAYS) begin
      last_way = WayW'(MAX_WAYS - 1);
    end else begin
      last_way = WayW'(cfg_i.ways_in_use - 3'd1);
    end
  end

  // replacement choice and updated row
  always_comb begin
    evict = !hit_q && !empty_q;
    if (hit_q) begin
      tgt_way = hit_way_q;
    end else if (empty_q) begin
      tgt_way = empty_way_q;
    end else if (vic_q) begin
      tgt_way = vic_way_q;
    end else begin
      tgt_way = '0;
    end
    new_row          = rd_row_q;
    new_row[tgt_way] = '{valid: 1'b1, tag: tag_q, stamp: stamp_q};
    hit_cnt_d        = hit_cnt_q + CNT_W'(hit_q);
    miss_cnt_d       = miss_cnt_q + CNT_W'(!hit_q);
    evict_cnt_d      = evict_cnt_q + CNT_W'(evict);
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    way_d       = way_q;
    second_d    = second_q;
    hit_d       = hit_q;
    hit_way_d   = hit_way_q;
    empty_d     = empty_q;
    empty_way_d = empty_way_q;
    vic_d       = vic_q;
    vic_way_d   = vic_way_q;
    min_stamp_d = min_stamp_q;
    mem_we      = 1'b0;
    mem_waddr   = set_q;
    mem_wdata   = new_row;
    mem_re      = 1'b0;
    fwd         = 1'b0;
    pop_ready_o = 1'b0;
    load        = 1'b0;
    scan_init   = 1'b0;
    cur         = rd_row_q[way_q];
    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        if (clr_q == SetW'(NumSets - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      S_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          mem_re    = 1'b1;
          second_d  = 1'b0;
          scan_init = 1'b1;
          state_d   = S_SCAN;
        end
      end
      S_SCAN: begin
        way_d = way_q + 1'b1;
        if (!cur.valid) begin
          if (!empty_q) begin
            empty_d     = 1'b1;
            empty_way_d = way_q;
          end
        end else if (cur.tag == tag_q) begin
          hit_d     = 1'b1;
          hit_way_d = way_q;
        end else if (!vic_q || cur.stamp < min_stamp_q) begin
          vic_d       = 1'b1;
          vic_way_d   = way_q;
          min_stamp_d = cur.stamp;
        end
        if (hit_d || way_q == last_way) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        if (out_free) begin
          load   = 1'b1;
          mem_we = 1'b1;
          if (modify_q && !second_q) begin
            second_d  = 1'b1;
            fwd       = 1'b1;
            scan_init = 1'b1;
            state_d   = S_SCAN;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (scan_init) begin
      way_d   = '0;
      hit_d   = 1'b0;
      empty_d = 1'b0;
      vic_d   = 1'b0;
    end
  end

  // set memory, registered read, modified row fed back for the second access
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_row_q <= mem_q[pop_set];
    end else if (fwd) begin
      rd_row_q <= new_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      second_q    <= 1'b0;
      stamp_q     <= '0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      evict_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      second_q <= second_d;
      if (load) begin
        stamp_q     <= stamp_q + 1'b1;
        hit_cnt_q   <= hit_cnt_d;
        miss_cnt_q  <= miss_cnt_d;
        evict_cnt_q <= evict_cnt_d;
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    way_q       <= way_d;
    hit_q       <= hit_d;
    hit_way_q   <= hit_way_d;
    empty_q     <= empty_d;
    empty_way_q <= empty_way_d;
    vic_q       <= vic_d;
    vic_way_q   <= vic_way_d;
    min_stamp_q <= min_stamp_d;
    if (pop_valid_i && pop_ready_o) begin
      modify_q <= pop_data_i[EntW-1];
      set_q    <= pop_set;
      tag_q    <= pop_data_i[TAG_W-1:0];
    end
    if (load) begin
      out_hit_q       <= hit_q;
      out_evict_q     <= evict;
      out_hit_tot_q   <= hit_cnt_d;
      out_miss_tot_q  <= miss_cnt_d;
      out_evict_tot_q <= evict_cnt_d;
      out_last_q      <= !(modify_q && !second_q);
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.was_hit        = out_hit_q;
  assign res_o.was_eviction   = out_evict_q;
  assign res_o.hit_total      = out_hit_tot_q;
  assign res_o.miss_total     = out_miss_tot_q;
  assign res_o.eviction_total = out_evict_tot_q;
  assign res_o.last           = out_last_q;

  `SACL_ASSERT(a_count_sum, 32'(hit_cnt_q + miss_cnt_q) == stamp_q, "hit plus miss count off")
  `SACL_ASSERT_IMP(a_hit_no_evict, out_valid_q, !(out_hit_q && out_evict_q), "hit with eviction")
  `SACL_ASSERT_IMP(a_second_hit, load && second_q, hit_q, "second modify access missed")
  `SACL_ASSERT_IMP(a_scan_range, state_q == S_SCAN, way_q <= last_way, "scan past last way")

endmodule
